// File: design/midpoint_ellipse_rasterizer_macros.svh
// assertion macros shared by the ellipse rasterizer rtl
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MER_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mer_pkg.sv
// shared types, constants and microprogram of the ellipse rasterizer
package mer_pkg;

  // field widths
  localparam int CW  = 11;
  localparam int AW  = 10;
  localparam int OW  = CW + 2;
  // squared semi-axis and its double
  localparam int SQW = 2 * AW;
  localparam int A2W = SQW + 1;
  // multiplier operand and product widths
  localparam int MAW = (A2W > CW) ? A2W : CW;
  localparam int MBW = (SQW > 2 * CW) ? SQW : 2 * CW;
  localparam int PW  = MAW + MBW;
  // decision accumulator
  localparam int DW  = PW + 5;
  // microprogram step counter
  localparam int UW  = 6;

  typedef logic [UW-1:0] ustep_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_REG1 = 2'd1,
    PH_REG2 = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    MA_A, MA_B, MA_X, MA_Y, MA_A2, MA_B2
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_A, MB_AM1, MB_B, MB_BB, MB_PROD, MB_TX, MB_X, MB_Y
  } mul_b_t;

  typedef enum logic [1:0] {
    AOP_NONE, AOP_LOAD, AOP_ADD, AOP_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    AS_PROD, AS_PROD2, AS_A2, AS_B2, AS_BBH, AS_AAH
  } acc_src_t;

  typedef enum logic [2:0] {
    JC_NEXT, JC_ALWAYS, JC_NOT_GT, JC_NEG, JC_XZERO, JC_DISPATCH
  } jump_t;

  // one control word
  typedef struct packed {
    jump_t    jc;
    ustep_t   target;
    logic     mul_en;
    mul_a_t   ma;
    mul_b_t   mb;
    logic     hold_en;
    acc_op_t  aop;
    acc_src_t asrc;
    logic     ld_aa;
    logic     ld_bb;
    logic     dec_x;
    logic     inc_y;
    logic     ld_tx;
    logic     ph_ld;
    phase_t   ph_val;
    logic     emit;
    logic     emit_last;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic   gt;
    logic   neg;
    logic   xzero;
    phase_t phase;
  } stat_t;

  // one mirrored point
  typedef struct packed {
    logic [OW-1:0] rx;
    logic [OW-1:0] lx;
    logic [OW-1:0] ly;
    logic [OW-1:0] uy;
    logic          last;
  } pt_t;

  // microprogram addresses
  localparam ustep_t U_IDLE  = 6'd0;
  localparam ustep_t U_ST0   = 6'd1;
  localparam ustep_t U_ST1   = 6'd2;
  localparam ustep_t U_ST2   = 6'd3;
  localparam ustep_t U_ST3   = 6'd4;
  localparam ustep_t U_ST4   = 6'd5;
  localparam ustep_t U_ST5   = 6'd6;
  localparam ustep_t U_ST6   = 6'd7;
  localparam ustep_t U_ST7   = 6'd8;
  localparam ustep_t U_R1_0  = 6'd9;
  localparam ustep_t U_R1_1  = 6'd10;
  localparam ustep_t U_R1_2  = 6'd11;
  localparam ustep_t U_R1_3  = 6'd12;
  localparam ustep_t U_R1P_0 = 6'd13;
  localparam ustep_t U_R1P_1 = 6'd14;
  localparam ustep_t U_R1P_2 = 6'd15;
  localparam ustep_t U_R1N_0 = 6'd16;
  localparam ustep_t U_R1N_1 = 6'd17;
  localparam ustep_t U_R1N_2 = 6'd18;
  localparam ustep_t U_R1N_3 = 6'd19;
  localparam ustep_t U_R2I_0 = 6'd20;
  localparam ustep_t U_R2I_1 = 6'd21;
  localparam ustep_t U_R2I_2 = 6'd22;
  localparam ustep_t U_R2I_3 = 6'd23;
  localparam ustep_t U_R2I_4 = 6'd24;
  localparam ustep_t U_R2I_5 = 6'd25;
  localparam ustep_t U_R2I_6 = 6'd26;
  localparam ustep_t U_R2I_7 = 6'd27;
  localparam ustep_t U_R2I_8 = 6'd28;
  localparam ustep_t U_R2I_9 = 6'd29;
  localparam ustep_t U_R2_0  = 6'd30;
  localparam ustep_t U_R2_1  = 6'd31;
  localparam ustep_t U_R2P_0 = 6'd32;
  localparam ustep_t U_R2P_1 = 6'd33;
  localparam ustep_t U_R2P_2 = 6'd34;
  localparam ustep_t U_R2P_3 = 6'd35;
  localparam ustep_t U_R2N_0 = 6'd36;
  localparam ustep_t U_R2N_1 = 6'd37;
  localparam ustep_t U_R2N_2 = 6'd38;
  localparam ustep_t U_R2L   = 6'd39;

  localparam ctrl_t CTRL_NOP = '{
    jc: JC_NEXT, target: U_IDLE, mul_en: 1'b0, ma: MA_A, mb: MB_A, hold_en: 1'b0,
    aop: AOP_NONE, asrc: AS_PROD, ld_aa: 1'b0, ld_bb: 1'b0, dec_x: 1'b0,
    inc_y: 1'b0, ld_tx: 1'b0, ph_ld: 1'b0, ph_val: PH_IDLE, emit: 1'b0,
    emit_last: 1'b0
  };

  // word builders
  function automatic ctrl_t w_mul(input ctrl_t w, input mul_a_t a, input mul_b_t b);
    ctrl_t r;
    r = w;
    r.mul_en = 1'b1;
    r.ma = a;
    r.mb = b;
    return r;
  endfunction

  function automatic ctrl_t w_acc(input ctrl_t w, input acc_op_t op, input acc_src_t s);
    ctrl_t r;
    r = w;
    r.aop = op;
    r.asrc = s;
    return r;
  endfunction

  function automatic ctrl_t w_jmp(input ctrl_t w, input jump_t jc, input ustep_t t);
    ctrl_t r;
    r = w;
    r.jc = jc;
    r.target = t;
    return r;
  endfunction

  // microprogram rom
  function automatic ctrl_t ucode(input ustep_t pc);
    ctrl_t w;
    w = CTRL_NOP;
    case (pc)
      U_IDLE:  w.jc = JC_DISPATCH;
      // start: d = 2bb*a*(a-1) + bb/2 + 2aa - 2aa*bb
      U_ST0:   w = w_mul(w, MA_A, MB_A);
      U_ST1: begin
        w = w_mul(w, MA_B, MB_B);
        w.ld_aa = 1'b1;
      end
      U_ST2: begin
        w = w_mul(w, MA_A, MB_AM1);
        w.ld_bb = 1'b1;
      end
      U_ST3:   w = w_mul(w, MA_B2, MB_PROD);
      U_ST4:   w = w_mul(w_acc(w, AOP_LOAD, AS_PROD), MA_A2, MB_BB);
      U_ST5:   w = w_acc(w, AOP_SUB, AS_PROD);
      U_ST6:   w = w_acc(w, AOP_ADD, AS_A2);
      U_ST7:   w = w_jmp(w_acc(w, AOP_ADD, AS_BBH), JC_ALWAYS, U_IDLE);
      // region one: test 2bb*tx > 2aa*y
      U_R1_0:  w = w_mul(w, MA_B2, MB_TX);
      U_R1_1: begin
        w = w_mul(w, MA_A2, MB_Y);
        w.hold_en = 1'b1;
      end
      U_R1_2:  w = w_jmp(w, JC_NOT_GT, U_R2I_0);
      U_R1_3: begin
        w = w_jmp(w, JC_NEG, U_R1N_0);
        w.emit = 1'b1;
      end
      // region one, diagonal move
      U_R1P_0: begin
        w.dec_x = 1'b1;
        w.inc_y = 1'b1;
        w.ld_tx = 1'b1;
      end
      U_R1P_1: w = w_mul(w, MA_B2, MB_X);
      U_R1P_2: w = w_jmp(w_mul(w_acc(w, AOP_SUB, AS_PROD2), MA_A2, MB_Y), JC_ALWAYS, U_R1N_2);
      // region one, vertical move
      U_R1N_0: begin
        w.inc_y = 1'b1;
        w.ld_tx = 1'b1;
      end
      U_R1N_1: w = w_mul(w, MA_A2, MB_Y);
      U_R1N_2: w = w_acc(w, AOP_ADD, AS_PROD2);
      U_R1N_3: w = w_jmp(w_acc(w, AOP_ADD, AS_A2), JC_ALWAYS, U_IDLE);
      // region two seed: 2bb*(x*x+1) - 4bb*x + 2aa*(y*y+y-bb) + aa/2
      U_R2I_0: begin
        w = w_mul(w, MA_X, MB_X);
        w.ph_ld = 1'b1;
        w.ph_val = PH_REG2;
      end
      U_R2I_1: w = w_mul(w, MA_B2, MB_PROD);
      U_R2I_2: w = w_mul(w_acc(w, AOP_LOAD, AS_PROD), MA_B2, MB_X);
      U_R2I_3: w = w_acc(w, AOP_ADD, AS_B2);
      U_R2I_4: w = w_mul(w_acc(w, AOP_SUB, AS_PROD2), MA_Y, MB_Y);
      U_R2I_5: w = w_mul(w, MA_A2, MB_PROD);
      U_R2I_6: w = w_mul(w_acc(w, AOP_ADD, AS_PROD), MA_A2, MB_Y);
      U_R2I_7: w = w_mul(w_acc(w, AOP_ADD, AS_PROD), MA_A2, MB_BB);
      U_R2I_8: w = w_acc(w, AOP_SUB, AS_PROD);
      U_R2I_9: w = w_acc(w, AOP_ADD, AS_AAH);
      // region two step
      U_R2_0:  w = w_jmp(w, JC_XZERO, U_R2L);
      U_R2_1: begin
        w = w_jmp(w, JC_NEG, U_R2N_0);
        w.emit = 1'b1;
      end
      // region two, horizontal move
      U_R2P_0: w.dec_x = 1'b1;
      U_R2P_1: w = w_mul(w, MA_B2, MB_X);
      U_R2P_2: w = w_acc(w, AOP_SUB, AS_PROD2);
      U_R2P_3: w = w_jmp(w_acc(w, AOP_ADD, AS_B2), JC_ALWAYS, U_IDLE);
      // region two, diagonal move
      U_R2N_0: begin
        w.dec_x = 1'b1;
        w.inc_y = 1'b1;
      end
      U_R2N_1: w = w_mul(w, MA_A2, MB_Y);
      U_R2N_2: w = w_jmp(w_mul(w_acc(w, AOP_ADD, AS_PROD2), MA_B2, MB_X), JC_ALWAYS, U_R2P_2);
      // final point on the vertical axis
      U_R2L: begin
        w = w_jmp(w, JC_ALWAYS, U_IDLE);
        w.emit = 1'b1;
        w.emit_last = 1'b1;
        w.ph_ld = 1'b1;
        w.ph_val = PH_IDLE;
      end
      default: w = w_jmp(w, JC_ALWAYS, U_IDLE);
    endcase
    return w;
  endfunction

endpackage

// File: design/mer_useq.sv
// microprogram sequencer: step counter, control rom and jump logic
module mer_useq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            op,
  input  mer_pkg::stat_t  stat,
  input  logic            slot_free,
  output logic            in_ready,
  output mer_pkg::ctrl_t  cw,
  output logic            fire
);
  import mer_pkg::*;

  ustep_t pc;
  ustep_t pc_next;
  ustep_t pc_inc;

  // control word of the current step
  always_comb begin
    cw = ucode(pc);
  end

  assign in_ready = (cw.jc == JC_DISPATCH);
  // an emitting step waits for a free output slot
  assign fire = (cw.jc != JC_DISPATCH) && (!cw.emit || slot_free);
  assign pc_inc = pc + 1'b1;

  // next step
  always_comb begin
    pc_next = pc;
    if (cw.jc == JC_DISPATCH) begin
      if (in_valid) begin
        if (!op) begin
          pc_next = U_ST0;
        end else if (stat.phase == PH_REG1) begin
          pc_next = U_R1_0;
        end else if (stat.phase == PH_REG2) begin
          pc_next = U_R2_0;
        end
      end
    end else if (fire) begin
      case (cw.jc)
        JC_NEXT:   pc_next = pc_inc;
        JC_ALWAYS: pc_next = cw.target;
        JC_NOT_GT: pc_next = stat.gt ? pc_inc : cw.target;
        JC_NEG:    pc_next = stat.neg ? cw.target : pc_inc;
        JC_XZERO:  pc_next = stat.xzero ? cw.target : pc_inc;
        default:   pc_next = U_IDLE;
      endcase
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= U_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: design/mer_dpath.sv
// datapath: held operands, offsets, shared multiplier and decision accumulator
module mer_dpath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [mer_pkg::CW-1:0] center_x,
  input  logic [mer_pkg::CW-1:0] center_y,
  input  logic [mer_pkg::AW-1:0] semi_a,
  input  logic [mer_pkg::AW-1:0] semi_b,
  input  mer_pkg::ctrl_t         cw,
  input  logic                   fire,
  output mer_pkg::stat_t         stat,
  output mer_pkg::pt_t           pt
);
  import mer_pkg::*;

  logic [CW-1:0]  held_cx;
  logic [CW-1:0]  held_cy;
  logic [AW-1:0]  held_a;
  logic [AW-1:0]  held_b;
  logic [SQW-1:0] aa;
  logic [SQW-1:0] bb;
  logic [CW-1:0]  x;
  logic [CW-1:0]  y;
  logic [CW-1:0]  tx;
  logic [PW-1:0]  prod;
  logic [PW-1:0]  hold;
  logic [DW-1:0]  acc;
  phase_t         phase;

  logic [AW-1:0]  am1;
  logic [CW-1:0]  x_m1;
  logic [CW-1:0]  a_off;
  logic [MAW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic [PW-1:0]  mul_p;
  logic [DW-1:0]  opnd;

  assign am1   = held_a - 1'b1;
  assign x_m1  = x - 1'b1;
  assign a_off = CW'(semi_a);

  // multiplier operand select
  always_comb begin
    case (cw.ma)
      MA_A:    mul_a = MAW'(held_a);
      MA_B:    mul_a = MAW'(held_b);
      MA_X:    mul_a = MAW'(x);
      MA_Y:    mul_a = MAW'(y);
      MA_A2:   mul_a = MAW'({aa, 1'b0});
      MA_B2:   mul_a = MAW'({bb, 1'b0});
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (cw.mb)
      MB_A:    mul_b = MBW'(held_a);
      MB_AM1:  mul_b = MBW'(am1);
      MB_B:    mul_b = MBW'(held_b);
      MB_BB:   mul_b = MBW'(bb);
      MB_PROD: mul_b = prod[MBW-1:0];
      MB_TX:   mul_b = MBW'(tx);
      MB_X:    mul_b = MBW'(x);
      MB_Y:    mul_b = MBW'(y);
      default: mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // accumulator operand select
  always_comb begin
    case (cw.asrc)
      AS_PROD:  opnd = DW'(prod);
      AS_PROD2: opnd = DW'({prod, 1'b0});
      AS_A2:    opnd = DW'({aa, 1'b0});
      AS_B2:    opnd = DW'({bb, 1'b0});
      AS_BBH:   opnd = DW'(bb[SQW-1:1]);
      AS_AAH:   opnd = DW'(aa[SQW-1:1]);
      default:  opnd = '0;
    endcase
  end

  // drawing phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (start) begin
      phase <= PH_REG1;
    end else if (fire && cw.ph_ld) begin
      phase <= cw.ph_val;
    end
  end

  // operand, offset and decision registers
  always_ff @(posedge clk) begin
    if (start) begin
      held_cx <= center_x;
      held_cy <= center_y;
      held_a  <= semi_a;
      held_b  <= semi_b;
      x       <= a_off;
      y       <= '0;
      tx      <= a_off;
    end else if (fire) begin
      if (cw.ld_aa) begin
        aa <= prod[SQW-1:0];
      end
      if (cw.ld_bb) begin
        bb <= prod[SQW-1:0];
      end
      if (cw.mul_en) begin
        prod <= mul_p;
      end
      if (cw.hold_en) begin
        hold <= prod;
      end
      if (cw.dec_x) begin
        x <= x_m1;
      end
      if (cw.inc_y) begin
        y <= y + 1'b1;
      end
      if (cw.ld_tx) begin
        tx <= x_m1;
      end
      case (cw.aop)
        AOP_LOAD: acc <= opnd;
        AOP_ADD:  acc <= acc + opnd;
        AOP_SUB:  acc <= acc - opnd;
        default:  acc <= acc;
      endcase
    end
  end

  // flags for the sequencer
  assign stat.gt    = (hold > prod);
  assign stat.neg   = acc[DW-1];
  assign stat.xzero = (x == '0);
  assign stat.phase = phase;

  // current point mirrored about the center
  assign pt.rx   = OW'(held_cx) + OW'(x);
  assign pt.lx   = OW'(held_cx) - OW'(x);
  assign pt.ly   = OW'(held_cy) + OW'(y);
  assign pt.uy   = OW'(held_cy) - OW'(y);
  assign pt.last = cw.emit_last;

endmodule

// File: design/midpoint_ellipse_rasterizer.sv
// top level of the midpoint ellipse rasterizer
// Usage:
//   Input channel (in_valid/in_ready) takes one word per item. op = 0 starts a
//   new ellipse from center_x/center_y and semi_a/semi_b and gives no output;
//   op = 1 steps to the next point and gives one output word with the four
//   mirrored coordinates, and last set on the point on the vertical axis.
//   A step with no ellipse in progress is taken and gives nothing.
//   Output channel (out_valid/out_ready) is a single output register.
// Sequencing (one shared multiplier; a word is taken once the last one is done):
//   start: computes the first region-one decision and gives no output
//   region-one point: result loaded after the 2bb*tx > 2aa*y test
//   region-two point: result loaded after the x = 0 test
//   step that crosses into region two: region-two decision seeded first
//   last point: result loaded straight after the x = 0 test; idle step: nothing run
// Reset (rst, synchronous) returns to the dispatch step with no ellipse in
// progress and the output register empty. When the receiver stalls, the
// emitting step waits for the output register, which adds the stall cycles.
`include "midpoint_ellipse_rasterizer_macros.svh"
module midpoint_ellipse_rasterizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [mer_pkg::CW-1:0]        center_x,
  input  logic [mer_pkg::CW-1:0]        center_y,
  input  logic [mer_pkg::AW-1:0]        semi_a,
  input  logic [mer_pkg::AW-1:0]        semi_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [mer_pkg::OW-1:0] right_x,
  output logic signed [mer_pkg::OW-1:0] left_x,
  output logic signed [mer_pkg::OW-1:0] lower_y,
  output logic signed [mer_pkg::OW-1:0] upper_y,
  output logic                          last
);
  import mer_pkg::*;

  ctrl_t cw;
  stat_t stat;
  pt_t   pt;
  logic  fire;
  logic  slot_free;
  logic  start;
  logic  pt_load;

  assign slot_free = !out_valid || out_ready;
  assign start     = in_valid && in_ready && !op;
  assign pt_load   = fire && cw.emit;

  // sequencer
  mer_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .stat      (stat),
    .slot_free (slot_free),
    .in_ready  (in_ready),
    .cw        (cw),
    .fire      (fire)
  );

  // datapath
  mer_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .center_x (center_x),
    .center_y (center_y),
    .semi_a   (semi_a),
    .semi_b   (semi_b),
    .cw       (cw),
    .fire     (fire),
    .stat     (stat),
    .pt       (pt)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pt_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register word
  always_ff @(posedge clk) begin
    if (pt_load) begin
      right_x <= $signed(pt.rx);
      left_x  <= $signed(pt.lx);
      lower_y <= $signed(pt.ly);
      upper_y <= $signed(pt.uy);
      last    <= pt.last;
    end
  end

  // checks
  `MER_ASSERT_SAME(a_last_on_axis, out_valid && last, right_x == left_x, "last point not on axis")
  `MER_ASSERT_NEXT(a_last_ends, pt_load && cw.emit_last, stat.phase == PH_IDLE, "phase kept after last")
  `MER_ASSERT_NEXT(a_idle_step, in_valid && in_ready && op && (stat.phase != PH_REG1) && (stat.phase != PH_REG2), in_ready, "idle step left dispatch")

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the midpoint ellipse rasterizer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mer_pkg::*;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;
  localparam int STUCK_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_WORDS   = 2000;
  localparam int QUIET_FROM   = 1800;
  localparam int DIR_ROWS     = 25;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_POINT
  } row_kind_t;

  typedef struct packed {
    logic          op;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    row_kind_t     kind;
    pt_t           pt;
  } stim_row_t;

  localparam pt_t NO_PT = '0;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 op = 1'b0;
  logic [CW-1:0]        center_x = '0;
  logic [CW-1:0]        center_y = '0;
  logic [AW-1:0]        semi_a = '0;
  logic [AW-1:0]        semi_b = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [OW-1:0] right_x;
  logic signed [OW-1:0] left_x;
  logic signed [OW-1:0] lower_y;
  logic signed [OW-1:0] upper_y;
  logic                 last;

  midpoint_ellipse_rasterizer dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ellipse tracker state
  phase_t        el_phase = PH_IDLE;
  logic [CW-1:0] el_off_x = '0;
  logic [CW-1:0] el_off_y = '0;
  logic [CW-1:0] el_track_x = '0;
  logic [63:0]   el_dec = '0;
  logic [CW-1:0] el_cx = '0;
  logic [CW-1:0] el_cy = '0;
  logic [AW-1:0] el_a = '0;
  logic [AW-1:0] el_b = '0;

  pt_t pending_points[$];
  int  mismatches = 0;
  int  points_seen = 0;
  int  stuck_cycles = 0;
  bit  quiet = 1'b0;
  bit  calm_in = 1'b0;
  bit  calm_out = 1'b0;
  int  stall_left = 0;

  stim_row_t dir_rows[DIR_ROWS];

  // four-way mirror of the current offsets about the held center
  function automatic pt_t mirror_point(input logic is_last);
    pt_t p;
    p.rx = OW'(el_cx) + OW'(el_off_x);
    p.lx = OW'(el_cx) - OW'(el_off_x);
    p.ly = OW'(el_cy) + OW'(el_off_y);
    p.uy = OW'(el_cy) - OW'(el_off_y);
    p.last = is_last;
    return p;
  endfunction

  // advance the ellipse walk by one accepted word
  task automatic advance_ellipse(input logic w_op, input logic [CW-1:0] w_cx,
                                 input logic [CW-1:0] w_cy, input logic [AW-1:0] w_a,
                                 input logic [AW-1:0] w_b, output logic emitted,
                                 output pt_t pt);
    logic [63:0] aa, bb, a2, b2, a4, b4, x, y;
    logic done;
    emitted = 1'b0;
    pt = NO_PT;
    done = 1'b0;
    if (w_op == OP_START) begin
      el_cx = w_cx;
      el_cy = w_cy;
      el_a = w_a;
      el_b = w_b;
      aa = 64'(el_a) * 64'(el_a);
      bb = 64'(el_b) * 64'(el_b);
      x = 64'(el_a);
      el_off_x = CW'(el_a);
      el_off_y = '0;
      el_track_x = el_off_x;
      el_dec = 64'd2 * bb * x * (x - 64'd1) + bb / 64'd2 + 64'd2 * aa * (64'd1 - bb);
      el_phase = PH_REG1;
    end else if (el_phase == PH_REG1 || el_phase == PH_REG2) begin
      aa = 64'(el_a) * 64'(el_a);
      bb = 64'(el_b) * 64'(el_b);
      a2 = 64'd2 * aa;
      b2 = 64'd2 * bb;
      a4 = 64'd2 * a2;
      b4 = 64'd2 * b2;
      x = 64'(el_off_x);
      y = 64'(el_off_y);
      // region one, or the crossing into region two
      if (el_phase == PH_REG1) begin
        if (b2 * 64'(el_track_x) > a2 * y) begin
          pt = mirror_point(1'b0);
          emitted = 1'b1;
          done = 1'b1;
          if (el_dec[63]) begin
            y = y + 64'd1;
            el_dec = el_dec + a4 * y + a2;
            el_track_x = CW'(x - 64'd1);
          end else begin
            x = x - 64'd1;
            y = y + 64'd1;
            el_dec = el_dec - b4 * x + a4 * y + a2;
            el_track_x = CW'(x);
          end
          el_off_x = CW'(x);
          el_off_y = CW'(y);
        end else begin
          el_dec = b2 * (x * x + 64'd1) - b4 * x + a2 * (y * y + y - bb) + aa / 64'd2;
          el_phase = PH_REG2;
        end
      end
      // region two
      if (!done) begin
        emitted = 1'b1;
        if (x == 64'd0) begin
          pt = mirror_point(1'b1);
          el_phase = PH_IDLE;
        end else begin
          pt = mirror_point(1'b0);
          if (el_dec[63]) begin
            x = x - 64'd1;
            y = y + 64'd1;
            el_dec = el_dec + a4 * y - b4 * x + b2;
          end else begin
            x = x - 64'd1;
            el_dec = el_dec - b4 * x + b2;
          end
          el_off_x = CW'(x);
          el_off_y = CW'(y);
        end
      end
    end
  endtask

  // drive one input word, wait for it to be taken, then queue its expected point, if any
  task automatic issue_word(input logic w_op, input logic [CW-1:0] w_cx,
                            input logic [CW-1:0] w_cy, input logic [AW-1:0] w_a,
                            input logic [AW-1:0] w_b, input row_kind_t kind,
                            input pt_t typed_pt);
    logic emitted;
    pt_t pt;
    int gap;
    if (!quiet && !calm_in && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= w_op;
    center_x <= w_cx;
    center_y <= w_cy;
    semi_a <= w_a;
    semi_b <= w_b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_ellipse(w_op, w_cx, w_cy, w_a, w_b, emitted, pt);
    case (kind)
      ROW_PREDICT: if (emitted) pending_points.push_back(pt);
      ROW_POINT:   pending_points.push_back(typed_pt);
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [OW-1:0] got,
                             input logic [OW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("point %0d %s got %0d want %0d", points_seen, name,
                                $signed(got), $signed(want)));
  endtask

  // receiver stalls in bursts, with calm stretches
  always @(posedge clk) begin
    if (quiet || calm_out) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if ($urandom_range(0, 99) == 0) calm_out <= ~calm_out;
  end

  // compare each output word with the oldest pending point
  always @(posedge clk) begin : check_points
    pt_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("point %0d arrived with none pending (%0d,%0d,%0d,%0d)",
                                  points_seen, right_x, left_x, lower_y, upper_y));
      end else begin
        want = pending_points.pop_front();
        check_field("right_x", right_x, want.rx);
        check_field("left_x", left_x, want.lx);
        check_field("lower_y", lower_y, want.ly);
        check_field("upper_y", upper_y, want.uy);
        check_field("last", OW'(last), OW'(want.last));
      end
      points_seen++;
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int sent;
    int steps;
    int step_cap;
    logic [AW-1:0] ra, rb;
    dir_rows = '{
      // step straight after reset, then a degenerate ellipse with both axes zero
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_NONE,    NO_PT},
      '{OP_START, 11'd1000, 11'd1000, 10'd0,    10'd0,    ROW_NONE,    NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_POINT,
        '{13'd1000, 13'd1000, 13'd1000, 13'd1000, 1'b1}},
      '{OP_STEP,  11'd2047, 11'd2047, 10'd1023, 10'd1023, ROW_NONE,    NO_PT},
      // zero vertical axis walks x down with y held at zero
      '{OP_START, 11'd0,    11'd0,    10'd3,    10'd0,    ROW_NONE,    NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_POINT,
        '{13'd3, -13'sd3, 13'd0, 13'd0, 1'b0}},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_POINT,
        '{13'd2, -13'sd2, 13'd0, 13'd0, 1'b0}},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_POINT,
        '{13'd1, -13'sd1, 13'd0, 13'd0, 1'b0}},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_POINT,
        '{13'd0, 13'd0, 13'd0, 13'd0, 1'b1}},
      // largest center and axes
      '{OP_START, 11'd2047, 11'd2047, 10'd1023, 10'd1023, ROW_NONE,    NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_POINT,
        '{13'd3070, 13'd1024, 13'd2047, 13'd2047, 1'b0}},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_PREDICT, NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_PREDICT, NO_PT},
      // restart in the middle of a drawing
      '{OP_START, 11'd0,    11'd0,    10'd1023, 10'd1,    ROW_NONE,    NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_POINT,
        '{13'd1023, -13'sd1023, 13'd0, 13'd0, 1'b0}},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_PREDICT, NO_PT},
      '{OP_START, 11'd2047, 11'd0,    10'd1,    10'd1023, ROW_NONE,    NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_POINT,
        '{13'd2048, 13'd2046, 13'd0, 13'd0, 1'b0}},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_PREDICT, NO_PT},
      // zero horizontal axis gives a single last point
      '{OP_START, 11'd0,    11'd2047, 10'd0,    10'd1023, ROW_NONE,    NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_POINT,
        '{13'd0, 13'd0, 13'd2047, 13'd2047, 1'b1}},
      // unit circle crosses into region two, then steps while idle
      '{OP_START, 11'd1,    11'd1,    10'd1,    10'd1,    ROW_NONE,    NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_PREDICT, NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_PREDICT, NO_PT},
      '{OP_STEP,  11'd0,    11'd0,    10'd0,    10'd0,    ROW_PREDICT, NO_PT}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      issue_word(dir_rows[i].op, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].a,
                 dir_rows[i].b, dir_rows[i].kind, dir_rows[i].pt);

    // random ellipses, mostly small, some large and cut short, some dropped early
    sent = 0;
    while (sent < RAND_WORDS) begin
      calm_in = ($urandom_range(0, 5) == 0);
      quiet = (sent >= QUIET_FROM);
      ra = ($urandom_range(0, 7) == 0) ? AW'($urandom_range(0, 1023))
                                       : AW'($urandom_range(0, 24));
      rb = ($urandom_range(0, 7) == 0) ? AW'($urandom_range(0, 1023))
                                       : AW'($urandom_range(0, 24));
      issue_word(OP_START, CW'($urandom), CW'($urandom), ra, rb, ROW_PREDICT, NO_PT);
      sent++;
      step_cap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : 400;
      steps = 0;
      while (el_phase != PH_IDLE && steps < step_cap && sent < RAND_WORDS) begin
        issue_word(OP_STEP, CW'($urandom), CW'($urandom), AW'($urandom), AW'($urandom),
                   ROW_PREDICT, NO_PT);
        steps++;
        sent++;
        quiet = (sent >= QUIET_FROM);
      end
      // stray steps, mostly ignored by an idle block
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 2))
          issue_word(OP_STEP, CW'($urandom), CW'($urandom), AW'($urandom), AW'($urandom),
                     ROW_PREDICT, NO_PT);
    end
    in_valid <= 1'b0;

    // drain
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
